[rtl/assert_macros.svh]
// assertion macros used by the checker file ilid_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ilid_pkg.sv]
// types and constants of the indexed list insert/delete unit
// no dependencies
package ilid_pkg;

  localparam int CAPACITY = 64;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 16;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ       = 3'd0,
    CMD_INSERT_HEAD = 3'd1,
    CMD_INSERT_TAIL = 3'd2,
    CMD_INSERT_POS  = 3'd3,
    CMD_DELETE      = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         slot;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

[rtl/ilid_req_if.sv]
// request and response channel interfaces of the list unit
// depends on ilid_pkg
interface ilid_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [ilid_pkg::CMD_W-1:0]            command;
  logic signed [ilid_pkg::POS_W-1:0]     position;
  logic signed [ilid_pkg::DATA_W-1:0]    value;

  modport source (output valid, command, position, value, input ready);
  modport sink (input valid, command, position, value, output ready);
endinterface

interface ilid_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ilid_pkg::DATA_W-1:0]    read_value;
  logic                                  hit;
  logic [ilid_pkg::STATUS_W-1:0]         status;
  logic [ilid_pkg::COUNT_W-1:0]          length;

  modport source (output valid, read_value, hit, status, length, input ready);
  modport sink (input valid, read_value, hit, status, length, output ready);
endinterface

[rtl/ilid_cell.sv]
// one list slot: holds an entry and shifts toward either neighbor
// depends on ilid_pkg
module ilid_cell (
  input  logic                              clk,
  input  ilid_pkg::cell_ctrl_t              ctrl,
  input  logic [ilid_pkg::IDX_W-1:0]        index,
  input  logic signed [ilid_pkg::DATA_W-1:0] left,
  input  logic signed [ilid_pkg::DATA_W-1:0] right,
  output logic signed [ilid_pkg::DATA_W-1:0] entry,
  output logic signed [ilid_pkg::DATA_W-1:0] rd_data
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      ilid_pkg::CELL_INSERT: begin
        if (index == ctrl.slot) begin
          entry <= ctrl.value;
        end else if (index > ctrl.slot) begin
          entry <= left;
        end
      end
      ilid_pkg::CELL_DELETE: begin
        if (index >= ctrl.slot) begin
          entry <= right;
        end
      end
      default: begin
      end
    endcase
  end

  // only the addressed cell drives its entry onto the read bus
  assign rd_data = (index == ctrl.slot) ? entry : '0;

endmodule

[rtl/indexed_list_insert_delete_unit.sv]
// indexed list insert/delete unit: one request in, one response out
// response: registered, valid in the cycle after the request is taken
// throughput: one request per cycle while the response side is not stalled; every cell shifts in the same cycle
// the response register frees the request side as soon as it is taken
// reset: list length cleared, response channel empty; entry contents kept
module indexed_list_insert_delete_unit (
  input  logic        clk,
  input  logic        rst,
  ilid_req_if.sink    req,
  ilid_rsp_if.source  rsp
);

  localparam int CAP = ilid_pkg::CAPACITY;

  logic [ilid_pkg::COUNT_W-1:0]        count;
  logic [ilid_pkg::COUNT_W-1:0]        count_next;
  ilid_pkg::cell_ctrl_t                ctrl;
  ilid_pkg::status_t                   status_next;
  logic                                hit_next;
  logic                                fire;
  logic                                pos_neg;
  logic                                pos_lt;
  logic                                pos_le;
  logic                                full;
  logic [ilid_pkg::POS_W-1:0]          count_ext;
  logic signed [ilid_pkg::DATA_W-1:0]  entry [CAP];
  logic signed [ilid_pkg::DATA_W-1:0]  rd_bus [CAP];
  logic signed [ilid_pkg::DATA_W-1:0]  rd_any;

  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  assign count_ext = {{(ilid_pkg::POS_W - ilid_pkg::COUNT_W){1'b0}}, count};
  assign pos_neg   = req.position[ilid_pkg::POS_W-1];
  assign pos_lt    = !pos_neg && (req.position < count_ext);
  assign pos_le    = !pos_neg && (req.position <= count_ext);
  assign full      = (count == ilid_pkg::COUNT_W'(CAP));

  always_comb begin
    ctrl.op     = ilid_pkg::CELL_HOLD;
    ctrl.slot   = req.position[ilid_pkg::IDX_W-1:0];
    ctrl.value  = req.value;
    status_next = ilid_pkg::STATUS_DONE;
    hit_next    = 1'b0;
    count_next  = count;
    case (req.command)
      ilid_pkg::CMD_READ: begin
        if (pos_lt) begin
          hit_next = 1'b1;
        end else begin
          status_next = ilid_pkg::STATUS_RANGE;
        end
      end
      ilid_pkg::CMD_INSERT_HEAD, ilid_pkg::CMD_INSERT_TAIL, ilid_pkg::CMD_INSERT_POS: begin
        if (req.command == ilid_pkg::CMD_INSERT_HEAD) begin
          ctrl.slot = '0;
        end else if (req.command == ilid_pkg::CMD_INSERT_TAIL) begin
          ctrl.slot = count[ilid_pkg::IDX_W-1:0];
        end else if (pos_neg) begin
          ctrl.slot = '0;
        end
        if (req.command == ilid_pkg::CMD_INSERT_POS && !pos_neg && !pos_le) begin
          status_next = ilid_pkg::STATUS_RANGE;
        end else if (full) begin
          status_next = ilid_pkg::STATUS_FULL;
        end else begin
          ctrl.op    = ilid_pkg::CELL_INSERT;
          count_next = count + 1'b1;
        end
      end
      ilid_pkg::CMD_DELETE: begin
        if (pos_lt) begin
          ctrl.op    = ilid_pkg::CELL_DELETE;
          count_next = count - 1'b1;
        end else begin
          status_next = ilid_pkg::STATUS_RANGE;
        end
      end
      default: begin
        status_next = ilid_pkg::STATUS_RANGE;
      end
    endcase
    if (!fire) begin
      ctrl.op = ilid_pkg::CELL_HOLD;
    end
  end

  // the chain: each cell sees its left and right neighbor; an end cell sees its own entry on the open side
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic signed [ilid_pkg::DATA_W-1:0] left_val;
    logic signed [ilid_pkg::DATA_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = entry[i];
    end else begin : g_mid_l
      assign left_val = entry[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign right_val = entry[i];
    end else begin : g_mid_r
      assign right_val = entry[i+1];
    end
    ilid_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .index   (ilid_pkg::IDX_W'(i)),
      .left    (left_val),
      .right   (right_val),
      .entry   (entry[i]),
      .rd_data (rd_bus[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAP; i++) begin
      rd_any = rd_any | rd_bus[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.read_value <= hit_next ? rd_any : '1;
      rsp.hit        <= hit_next;
      rsp.status     <= status_next;
      rsp.length     <= count_next;
    end
  end

endmodule

[rtl/ilid_checker.sv]
// port-level checks of the list unit, bound to the top level
// depends on ilid_pkg and assert_macros.svh
`include "assert_macros.svh"

module ilid_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic signed [ilid_pkg::DATA_W-1:0] rsp_read_value,
  input logic                               rsp_hit,
  input logic [ilid_pkg::STATUS_W-1:0]      rsp_status,
  input logic [ilid_pkg::COUNT_W-1:0]       rsp_length
);

  // a pending item is not withdrawn
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  // a read hit is always a completed request
  `ASSERT_IMPL(a_hit_done, clk, rst, rsp_valid && rsp_hit, rsp_status == ilid_pkg::STATUS_DONE)

  // anything but a hit reports the all-ones value
  `ASSERT_IMPL(a_miss_value, clk, rst, rsp_valid && !rsp_hit, rsp_read_value == -1)

  // a full status is only reported with the list at capacity
  `ASSERT_IMPL(a_full_len, clk, rst, rsp_valid && rsp_status == ilid_pkg::STATUS_FULL,
    rsp_length == ilid_pkg::COUNT_W'(ilid_pkg::CAPACITY))

endmodule

bind indexed_list_insert_delete_unit ilid_checker u_ilid_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_value (rsp.read_value),
  .rsp_hit        (rsp.hit),
  .rsp_status     (rsp.status),
  .rsp_length     (rsp.length)
);

[bench/tb.sv]
`timescale 1ns / 1ps
// testbench of indexed_list_insert_delete_unit: random and directed requests,
// each reply checked against a behavioral list kept here
// depends on ilid_pkg, ilid_req_if, ilid_rsp_if and the unit itself
module tb;

  localparam logic [ilid_pkg::CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [ilid_pkg::CMD_W-1:0] CMD_UNDEF_HI = 3'd7;
  localparam logic signed [ilid_pkg::DATA_W-1:0] MISS_VALUE = -1;
  localparam logic signed [ilid_pkg::DATA_W-1:0] DATA_MIN =
    {1'b1, {(ilid_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [ilid_pkg::DATA_W-1:0] DATA_MAX =
    {1'b0, {(ilid_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [ilid_pkg::POS_W-1:0] POS_MIN = {1'b1, {(ilid_pkg::POS_W-1){1'b0}}};
  localparam logic signed [ilid_pkg::POS_W-1:0] POS_MAX = {1'b0, {(ilid_pkg::POS_W-1){1'b1}}};
  localparam int ITEMS_PER_PHASE = 150;
  localparam int FILL_ITEMS = 110;

  typedef struct {
    logic [ilid_pkg::CMD_W-1:0]         command;
    logic signed [ilid_pkg::POS_W-1:0]  position;
    logic signed [ilid_pkg::DATA_W-1:0] value;
  } list_req_t;

  typedef struct {
    logic signed [ilid_pkg::DATA_W-1:0] read_value;
    logic                               hit;
    logic [ilid_pkg::STATUS_W-1:0]      status;
    logic [ilid_pkg::COUNT_W-1:0]       length;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst;

  ilid_req_if req_ch ();
  ilid_rsp_if rsp_ch ();

  indexed_list_insert_delete_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  list_req_t queued_requests[$];
  list_rsp_t outstanding_replies[$];
  logic signed [ilid_pkg::DATA_W-1:0] list_vals [ilid_pkg::CAPACITY];
  int list_len = 0;
  int error_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int rsp_hold_left = 0;
  logic req_fire;

  // applies one request to the local list and returns the reply it should give
  function automatic list_rsp_t apply_request(list_req_t r);
    list_rsp_t rep;
    int slot;
    int i;
    rep = '{MISS_VALUE, 1'b0, ilid_pkg::STATUS_DONE, '0};
    case (r.command)
      ilid_pkg::CMD_READ: begin
        if (r.position >= 0 && int'(r.position) < list_len) begin
          rep.read_value = list_vals[int'(r.position)];
          rep.hit = 1'b1;
        end else begin
          rep.status = ilid_pkg::STATUS_RANGE;
        end
      end
      ilid_pkg::CMD_INSERT_HEAD, ilid_pkg::CMD_INSERT_TAIL, ilid_pkg::CMD_INSERT_POS: begin
        if (r.command == ilid_pkg::CMD_INSERT_HEAD) slot = 0;
        else if (r.command == ilid_pkg::CMD_INSERT_TAIL) slot = list_len;
        else slot = (r.position <= 0) ? 0 : int'(r.position);
        // range check wins over the full check
        if (slot > list_len) begin
          rep.status = ilid_pkg::STATUS_RANGE;
        end else if (list_len >= ilid_pkg::CAPACITY) begin
          rep.status = ilid_pkg::STATUS_FULL;
        end else begin
          for (i = list_len; i > slot; i--) list_vals[i] = list_vals[i-1];
          list_vals[slot] = r.value;
          list_len++;
        end
      end
      ilid_pkg::CMD_DELETE: begin
        if (r.position >= 0 && int'(r.position) < list_len) begin
          for (i = int'(r.position); i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end else begin
          rep.status = ilid_pkg::STATUS_RANGE;
        end
      end
      default: rep.status = ilid_pkg::STATUS_RANGE;
    endcase
    rep.length = ilid_pkg::COUNT_W'(list_len);
    return rep;
  endfunction

  function automatic list_req_t pick_request(bit filling);
    list_req_t r;
    int roll;
    int pr;
    roll = $urandom_range(99);
    if (roll < 3) r.command = ilid_pkg::CMD_W'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO));
    else if (filling)
      r.command = roll < 17 ? ilid_pkg::CMD_READ : roll < 27 ? ilid_pkg::CMD_DELETE :
                  roll < 50 ? ilid_pkg::CMD_INSERT_HEAD :
                  roll < 73 ? ilid_pkg::CMD_INSERT_TAIL : ilid_pkg::CMD_INSERT_POS;
    else
      r.command = roll < 23 ? ilid_pkg::CMD_READ : roll < 88 ? ilid_pkg::CMD_DELETE :
                  roll < 92 ? ilid_pkg::CMD_INSERT_HEAD :
                  roll < 96 ? ilid_pkg::CMD_INSERT_TAIL : ilid_pkg::CMD_INSERT_POS;
    pr = $urandom_range(99);
    if (pr < 50) r.position = ilid_pkg::POS_W'($urandom_range(15));
    else if (pr < 85) r.position = ilid_pkg::POS_W'($urandom_range(ilid_pkg::CAPACITY + 1));
    else if (pr < 95) r.position = ilid_pkg::POS_W'($urandom);
    else r.position = ilid_pkg::POS_W'(-int'($urandom_range(4, 1)));
    if ($urandom_range(99) < 85) begin
      r.value = $urandom;
    end else begin
      case ($urandom_range(3))
        0: r.value = DATA_MIN;
        1: r.value = DATA_MAX;
        2: r.value = '0;
        default: r.value = '1;
      endcase
    end
    return r;
  endfunction

  task automatic queue_request(logic [ilid_pkg::CMD_W-1:0] cmd,
                               logic signed [ilid_pkg::POS_W-1:0] pos,
                               logic signed [ilid_pkg::DATA_W-1:0] val);
    list_req_t r;
    r = '{cmd, pos, val};
    queued_requests.push_back(r);
  endtask

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic wait_for_idle();
    while (queued_requests.size() != 0 || req_ch.valid || outstanding_replies.size() != 0)
      @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    list_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = queued_requests.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.command <= nxt.command;
        req_ch.position <= nxt.position;
        req_ch.value <= nxt.value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // reply side backpressure, with an optional long hold-off
  always @(negedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold_left <= rsp_hold_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: check replies, predict on every accepted request
  always @(posedge clk) begin
    list_rsp_t got;
    list_rsp_t want;
    list_req_t taken;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.read_value, rsp_ch.hit, rsp_ch.status, rsp_ch.length};
        if (outstanding_replies.size() == 0) begin
          report_mismatch($sformatf("reply with none expected: value %0d hit %0b status %0d len %0d",
                                    got.read_value, got.hit, got.status, got.length));
        end else begin
          want = outstanding_replies.pop_front();
          if (got.read_value !== want.read_value || got.hit !== want.hit ||
              got.status !== want.status || got.length !== want.length)
            report_mismatch($sformatf(
              "expected value %0d hit %0b status %0d len %0d, got %0d %0b %0d %0d",
              want.read_value, want.hit, want.status, want.length,
              got.read_value, got.hit, got.status, got.length));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        taken = '{req_ch.command, req_ch.position, req_ch.value};
        outstanding_replies.push_back(apply_request(taken));
      end
    end
  end

  initial begin
    int phase;
    int k;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = ilid_pkg::CMD_READ;
    req_ch.position = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list corner cases
    queue_request(ilid_pkg::CMD_READ, 0, 0);
    queue_request(ilid_pkg::CMD_DELETE, 0, 0);
    queue_request(ilid_pkg::CMD_INSERT_POS, 1, 0);
    // build a short list through every insert flavor
    queue_request(ilid_pkg::CMD_INSERT_HEAD, 0, DATA_MAX);
    queue_request(ilid_pkg::CMD_INSERT_TAIL, POS_MAX, DATA_MIN);
    queue_request(ilid_pkg::CMD_INSERT_POS, POS_MIN, 0);
    queue_request(ilid_pkg::CMD_INSERT_POS, 3, '1);
    queue_request(ilid_pkg::CMD_INSERT_POS, POS_MAX, 32'h1234_5678);
    queue_request(ilid_pkg::CMD_INSERT_POS, 2, 32'h5a5a_5a5a);
    for (k = 0; k < 5; k++) queue_request(ilid_pkg::CMD_READ, ilid_pkg::POS_W'(k), 0);
    // reads at the length and far below zero miss
    queue_request(ilid_pkg::CMD_READ, 5, 0);
    queue_request(ilid_pkg::CMD_READ, POS_MIN, 0);
    queue_request(ilid_pkg::CMD_DELETE, POS_MAX, 0);
    queue_request(ilid_pkg::CMD_DELETE, 2, 0);
    queue_request(ilid_pkg::CMD_DELETE, 0, 0);
    queue_request(ilid_pkg::CMD_DELETE, 2, 0);
    queue_request(CMD_UNDEF_LO, 0, DATA_MAX);
    queue_request(CMD_UNDEF_HI, POS_MIN, DATA_MIN);
    queue_request(ilid_pkg::CMD_READ, 1, 0);
    wait_for_idle();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 70; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 70; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      // the reply side holds off while requests keep coming, so the input stalls
      if (phase == 0) rsp_hold_left = 120;
      for (k = 0; k < ITEMS_PER_PHASE; k++) queued_requests.push_back(pick_request(k < FILL_ITEMS));
      wait_for_idle();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0 && outstanding_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ilid_pkg.sv
rtl/ilid_req_if.sv
rtl/ilid_cell.sv
rtl/indexed_list_insert_delete_unit.sv
rtl/ilid_checker.sv
bench/tb.sv
